>>> design/kvt_pkg.sv
// kvt_pkg: shared types, command and status codes for the key/value table
`default_nettype none

package kvt_pkg;

	localparam int KVT_ENTRIES = 16;

	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_DEL = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	localparam logic signed [31:0] VALUE_MISSING = -32'sd1;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
	} slot_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} res_t;

endpackage

`default_nettype wire

>>> design/kvt_ram.sv
// kvt_ram: single write port, single read port synchronous memory
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/kvt_ctrl.sv
// kvt_ctrl: clearing pass, slot scan and read-modify-write sequencer
`default_nettype none

module kvt_ctrl
	import kvt_pkg::*;
#(
	parameter int ENTRIES = KVT_ENTRIES
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 command,
	input  wire logic signed [31:0]         key,
	input  wire logic signed [31:0]         value,
	output res_t                            res,
	input  wire logic                       res_ready,
	output logic                            k_we,
	output logic [$clog2(ENTRIES)-1:0]      k_waddr,
	output slot_t                           k_wdata,
	output logic [$clog2(ENTRIES)-1:0]      k_raddr,
	input  wire slot_t                      k_rdata,
	output logic                            v_we,
	output logic [$clog2(ENTRIES)-1:0]      v_waddr,
	output logic [31:0]                     v_wdata,
	output logic [$clog2(ENTRIES)-1:0]      v_raddr,
	input  wire logic [31:0]                v_rdata
);

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_GETV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      chk_q;
	logic [AW-1:0]      free_q;
	logic               free_found_q;
	logic [1:0]         cmd_q;
	logic [31:0]        key_q;
	logic [31:0]        val_q;
	logic signed [31:0] rv_q;
	logic [1:0]         st_q;

	logic          hit;
	logic          last;
	logic          free_any;
	logic [AW-1:0] free_idx;

	assign hit      = k_rdata.valid && (k_rdata.key == key_q);
	assign last     = (chk_q == LAST);
	assign free_any = free_found_q || !k_rdata.valid;
	assign free_idx = free_found_q ? free_q : chk_q;

	assign in_ready       = (state_q == ST_IDLE);
	assign res.valid      = (state_q == ST_DONE);
	assign res.read_value = rv_q;
	assign res.status     = st_q;

	always_comb begin
		k_raddr = (state_q == ST_SCAN) ? chk_q + AW'(1) : '0;
		v_raddr = chk_q;
		k_we    = 1'b0;
		k_waddr = chk_q;
		k_wdata = '0;
		v_we    = 1'b0;
		v_waddr = chk_q;
		v_wdata = val_q;
		if (state_q == ST_CLEAR) begin
			k_we = 1'b1;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				if (cmd_q == CMD_SET) begin
					v_we = 1'b1;
				end else if (cmd_q == CMD_DEL) begin
					k_we          = 1'b1;
					k_wdata.valid = 1'b0;
					k_wdata.key   = key_q;
				end
			end else if (last && cmd_q == CMD_SET && free_any) begin
				k_we          = 1'b1;
				k_waddr       = free_idx;
				k_wdata.valid = 1'b1;
				k_wdata.key   = key_q;
				v_we          = 1'b1;
				v_waddr       = free_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			chk_q        <= '0;
			free_q       <= '0;
			free_found_q <= 1'b0;
			cmd_q        <= CMD_GET;
			key_q        <= '0;
			val_q        <= '0;
			rv_q         <= '0;
			st_q         <= STAT_OK;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					chk_q <= chk_q + AW'(1);
					if (last) begin
						chk_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q        <= command;
						key_q        <= key;
						val_q        <= value;
						free_found_q <= 1'b0;
						if (command == CMD_GET || command == CMD_SET || command == CMD_DEL) begin
							state_q <= ST_SCAN;
						end else begin
							rv_q    <= '0;
							st_q    <= STAT_OK;
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (!k_rdata.valid && !free_found_q) begin
						free_q       <= chk_q;
						free_found_q <= 1'b1;
					end
					if (hit) begin
						rv_q <= '0;
						st_q <= STAT_OK;
						if (cmd_q == CMD_GET) begin
							state_q <= ST_GETV;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (last) begin
						state_q <= ST_DONE;
						rv_q    <= '0;
						if (cmd_q == CMD_GET) begin
							rv_q <= VALUE_MISSING;
							st_q <= STAT_NOT_FOUND;
						end else if (cmd_q == CMD_DEL) begin
							st_q <= STAT_NOT_FOUND;
						end else begin
							st_q <= free_any ? STAT_OK : STAT_FULL;
						end
					end else begin
						chk_q <= chk_q + AW'(1);
					end
				end
				ST_GETV: begin
					rv_q    <= v_rdata;
					st_q    <= STAT_OK;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					chk_q <= '0;
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					chk_q   <= '0;
				end
			endcase
		end
	end

	// table changes only during the clearing pass or a scan
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		(k_we || v_we) |-> (state_q == ST_CLEAR || state_q == ST_SCAN))
		else $error("memory write outside clear or scan");

	// a get never modifies the table
	a_get_readonly: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmd_q == CMD_GET) |-> (!k_we && !v_we))
		else $error("get wrote to the table");

	// value fetch follows a get hit only
	a_getv_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GETV) |-> ($past(state_q) == ST_SCAN && cmd_q == CMD_GET))
		else $error("value fetch without get hit");

	// full status only for a set request
	a_full_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == STAT_FULL) |-> (cmd_q == CMD_SET))
		else $error("full status on non-set request");

endmodule

`default_nettype wire

>>> design/key_value_table_unit.sv
// key_value_table_unit: top level of the bounded associative key/value table
// one request at a time: in_ready is high only while the controller is idle
// a scan reads one slot per cycle and stops at a hit, a get hit adds a value read
// after reset a clearing pass writes every key slot before the first request is taken
// results sit in an output register while the next request is taken
`default_nettype none

module key_value_table_unit
	import kvt_pkg::*;
#(
	parameter int ENTRIES = KVT_ENTRIES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status
);

	localparam int AW = $clog2(ENTRIES);

	res_t          res;
	logic          res_ready;
	logic          k_we;
	logic [AW-1:0] k_waddr;
	slot_t         k_wdata;
	logic [AW-1:0] k_raddr;
	slot_t         k_rdata;
	logic          v_we;
	logic [AW-1:0] v_waddr;
	logic [31:0]   v_wdata;
	logic [AW-1:0] v_raddr;
	logic [31:0]   v_rdata;

	logic               out_valid_q;
	logic signed [31:0] read_value_q;
	logic [1:0]         status_q;

	kvt_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.key      (key),
		.value    (value),
		.res      (res),
		.res_ready(res_ready),
		.k_we     (k_we),
		.k_waddr  (k_waddr),
		.k_wdata  (k_wdata),
		.k_raddr  (k_raddr),
		.k_rdata  (k_rdata),
		.v_we     (v_we),
		.v_waddr  (v_waddr),
		.v_wdata  (v_wdata),
		.v_raddr  (v_raddr),
		.v_rdata  (v_rdata)
	);

	kvt_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(k_waddr),
		.wdata(k_wdata),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	kvt_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(v_wdata),
		.raddr(v_raddr),
		.rdata(v_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			read_value_q <= res.read_value;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

`default_nettype wire

>>> tb/tb_key_value_table_unit.sv
// tb_key_value_table_unit: self-checking bench for the key/value table, random and directed requests
`timescale 1ns / 1ps

module tb_key_value_table_unit;
	import kvt_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int POOL_DEPTH = 48;

	class kv_scoreboard;
		typedef struct {
			logic signed [31:0] read_value;
			logic [1:0]         status;
		} answer_t;

		logic signed [31:0] slot_key[KVT_ENTRIES];
		logic signed [31:0] slot_value[KVT_ENTRIES];
		bit                 slot_used[KVT_ENTRIES];
		answer_t            pending[$];
		int                 mismatches;

		function new();
			mismatches = 0;
			for (int i = 0; i < KVT_ENTRIES; i++) begin
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_used[i] = 1'b0;
			end
		endfunction

		task report_mismatch(input string what);
			$display("[%0t] mismatch: %0s", $time, what);
			mismatches++;
		endtask

		function void note_request(input logic [1:0] cmd, input logic signed [31:0] k,
				input logic signed [31:0] v);
			int hit;
			int spare;
			answer_t answer;
			hit = -1;
			spare = -1;
			for (int i = 0; i < KVT_ENTRIES; i++) begin
				if (hit < 0 && slot_used[i] && slot_key[i] == k)
					hit = i;
				if (spare < 0 && !slot_used[i])
					spare = i;
			end
			answer.read_value = '0;
			answer.status = STAT_OK;
			case (cmd)
				CMD_GET: begin
					if (hit >= 0) begin
						answer.read_value = slot_value[hit];
					end else begin
						answer.read_value = VALUE_MISSING;
						answer.status = STAT_NOT_FOUND;
					end
				end
				CMD_SET: begin
					if (hit >= 0) begin
						slot_value[hit] = v;
					end else if (spare >= 0) begin
						slot_key[spare] = k;
						slot_value[spare] = v;
						slot_used[spare] = 1'b1;
					end else begin
						answer.status = STAT_FULL;
					end
				end
				CMD_DEL: begin
					if (hit >= 0)
						slot_used[hit] = 1'b0;
					else
						answer.status = STAT_NOT_FOUND;
				end
				default: begin
				end
			endcase
			pending.push_back(answer);
		endfunction

		task check_result(input logic signed [31:0] rv, input logic [1:0] st);
			answer_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result with no request waiting: value %h status %0d",
					rv, st));
			end else begin
				want = pending.pop_front();
				if (rv !== want.read_value)
					report_mismatch($sformatf("read_value %h, expected %h", rv,
						want.read_value));
				if (st !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic signed [31:0] key;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;

	kv_scoreboard       scoreboard;
	int                 requests_taken;
	int                 cycle_count;
	bit                 calm;
	logic signed [31:0] key_pool[POOL_DEPTH];

	key_value_table_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.status     (status)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (arst_n) begin
			if (out_valid && out_ready)
				scoreboard.check_result(read_value, status);
			if (in_valid && in_ready) begin
				scoreboard.note_request(command, key, value);
				requests_taken <= requests_taken + 1;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			if (calm) begin
				@(negedge clk);
			end else begin
				repeat ($urandom_range(1, 40)) @(negedge clk);
				if ($urandom_range(0, 2) == 0) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 13)) @(negedge clk);
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** key_value_table_unit: FAILED **");
		$finish;
	end

	task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] k,
			input logic signed [31:0] v);
		int gap;
		int taken_before;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key <= k;
		value <= v;
		taken_before = requests_taken;
		do @(negedge clk); while (requests_taken == taken_before);
	endtask

	function automatic logic signed [31:0] pick_key(input int pool_size);
		if ($urandom_range(0, 99) < 88)
			return key_pool[$urandom_range(0, pool_size - 1)];
		return $urandom;
	endfunction

	task automatic random_requests(input int count, input int pool_size);
		int roll;
		logic [1:0] cmd;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 36)
				cmd = CMD_GET;
			else if (roll < 72)
				cmd = CMD_SET;
			else if (roll < 94)
				cmd = CMD_DEL;
			else
				cmd = CMD_UNUSED;
			send_request(cmd, pick_key(pool_size), $urandom);
		end
	endtask

	initial begin
		scoreboard = new();
		requests_taken = 0;
		cycle_count = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_GET;
		key = '0;
		value = '0;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sh0000_0000;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_DEPTH; i++)
			key_pool[i] = $urandom;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty table, unused code, extreme keys and values
		send_request(CMD_GET, 32'sh0000_0000, 32'sh0000_0000);
		send_request(CMD_DEL, 32'sh7fff_ffff, 32'sh0000_0000);
		send_request(CMD_UNUSED, -32'sd1, 32'sh1234_5678);
		send_request(CMD_SET, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(CMD_SET, 32'sh7fff_ffff, 32'sh8000_0000);
		send_request(CMD_SET, 32'sh0000_0000, -32'sd1);
		send_request(CMD_SET, -32'sd1, 32'sh0000_0000);
		send_request(CMD_GET, 32'sh8000_0000, 32'sh0000_0000);
		send_request(CMD_GET, -32'sd1, 32'sh0000_0000);
		send_request(CMD_SET, 32'sh8000_0000, 32'sh55aa_55aa);
		send_request(CMD_GET, 32'sh8000_0000, 32'sh0000_0000);
		// fill the remaining slots, then overflow
		for (int i = 0; i < KVT_ENTRIES - 4; i++)
			send_request(CMD_SET, 100 + i, $urandom);
		send_request(CMD_SET, 32'sd200, 32'sh0bad_cafe);
		send_request(CMD_SET, 32'sh0000_0000, 32'sd7);
		send_request(CMD_DEL, 32'sh7fff_ffff, 32'sh0000_0000);
		send_request(CMD_SET, 32'sd300, 32'sh0f0f_0f0f);
		send_request(CMD_GET, 32'sd300, 32'sh0000_0000);

		random_requests(400, 6);
		random_requests(400, 24);
		random_requests(300, POOL_DEPTH);
		calm = 1'b1;
		random_requests(200, 20);

		in_valid <= 1'b0;
		while (scoreboard.pending.size() != 0)
			@(negedge clk);
		repeat (KVT_ENTRIES + 8) @(negedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0)
			$display("** key_value_table_unit: PASSED **");
		else
			$display("** key_value_table_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
design/kvt_pkg.sv
design/kvt_ram.sv
design/kvt_ctrl.sv
design/key_value_table_unit.sv
tb/tb_key_value_table_unit.sv
